// ----- design/srp_pkg.sv -----
// Shared types, constants and functions for the Serpent-128 block cipher core.
`timescale 1ns / 1ps
package srp_pkg;

    localparam int NumSubkeys = 33;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ENCRYPT = 2'd1,
        CMD_DECRYPT = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Controller to datapath.
    typedef struct packed {
        logic             start;      // load working block from input, apply IP
        logic             round;      // run one round on the working block
        logic             decrypt;    // direction of the round
        logic [4:0]       rnd;        // round number
        logic             last;       // round 31: key XOR with subkey 32
        logic             final_perm; // apply FP to the working block
        logic [4:0]       key_rnd;    // subkey to fetch for the next cycle
    } dp_cmd_t;

    typedef logic [3:0] nib_t;

    // Forward S-box rows, packed with entry 0 in the low nibble.
    function automatic nib_t sbox_fwd(input logic [2:0] box, input nib_t x);
        nib_t r;
        begin
            unique case (box)
                3'd0: r = nib_t'(64'hC90724DEB56A1F83 >> (x * 4));
                3'd1: r = nib_t'(64'h43D68EB1A50972CF >> (x * 4));
                3'd2: r = nib_t'(64'h25B04E1DFAC39768 >> (x * 4));
                3'd3: r = nib_t'(64'hE57A421D369C8BF0 >> (x * 4));
                3'd4: r = nib_t'(64'hD7E9A4526B0C38F1 >> (x * 4));
                3'd5: r = nib_t'(64'h176D8E30C9A4B25F >> (x * 4));
                3'd6: r = nib_t'(64'h0A3DF19EB6485C27 >> (x * 4));
                default: r = nib_t'(64'h6539AC47B28E0FD1 >> (x * 4));
            endcase
            sbox_fwd = r;
        end
    endfunction

    function automatic nib_t sbox_inv(input logic [2:0] box, input nib_t x);
        nib_t r;
        begin
            r = 4'd0;
            for (int v = 0; v < 16; v++) begin
                if (sbox_fwd(box, nib_t'(v)) == x) begin
                    r = nib_t'(v);
                end
            end
            sbox_inv = r;
        end
    endfunction

    // Out bit i takes in bit (mult*i mod 127); bit 127 kept.
    function automatic logic [127:0] permute(input logic [127:0] x, input int mult);
        logic [127:0] t;
        begin
            for (int i = 0; i < 127; i++) begin
                t[i] = x[(mult * i) % 127];
            end
            t[127] = x[127];
            permute = t;
        end
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [127:0] lin_fwd(input logic [127:0] w);
        logic [127:0] p;
        logic [31:0]  x0, x1, x2, x3;
        begin
            p  = permute(w, 4);
            x0 = p[31:0];
            x1 = p[63:32];
            x2 = p[95:64];
            x3 = p[127:96];
            x0 = rotl(x0, 13);
            x2 = rotl(x2, 3);
            x1 = x1 ^ x0 ^ x2;
            x3 = x3 ^ x2 ^ (x0 << 3);
            x1 = rotl(x1, 1);
            x3 = rotl(x3, 7);
            x0 = x0 ^ x1 ^ x3;
            x2 = x2 ^ x3 ^ (x1 << 7);
            x0 = rotl(x0, 5);
            x2 = rotl(x2, 22);
            lin_fwd = permute({x3, x2, x1, x0}, 32);
        end
    endfunction

    function automatic logic [127:0] lin_inv(input logic [127:0] w);
        logic [127:0] p;
        logic [31:0]  x0, x1, x2, x3;
        begin
            p  = permute(w, 4);
            x0 = p[31:0];
            x1 = p[63:32];
            x2 = p[95:64];
            x3 = p[127:96];
            x2 = rotl(x2, 10);
            x0 = rotl(x0, 27);
            x2 = x2 ^ x3 ^ (x1 << 7);
            x0 = x0 ^ x1 ^ x3;
            x3 = rotl(x3, 25);
            x1 = rotl(x1, 31);
            x3 = x3 ^ x2 ^ (x0 << 3);
            x1 = x1 ^ x0 ^ x2;
            x2 = rotl(x2, 29);
            x0 = rotl(x0, 19);
            lin_inv = permute({x3, x2, x1, x0}, 32);
        end
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] w, input logic [2:0] box,
                                           input logic inv);
        logic [127:0] r;
        begin
            for (int n = 0; n < 32; n++) begin
                r[n*4 +: 4] = inv ? sbox_inv(box, w[n*4 +: 4]) : sbox_fwd(box, w[n*4 +: 4]);
            end
            subst = r;
        end
    endfunction

endpackage

// ----- design/srp_ctrl.sv -----
// Round sequencer for the Serpent-128 core.
`timescale 1ns / 1ps
module srp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             cmd,
    output logic                   out_valid,
    input  logic                   out_ready,
    output srp_pkg::dp_cmd_t       dp_cmd,
    output logic                   key_we
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] rnd_reg, rnd_next;
    logic       dec_reg, dec_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;
    assign key_we    = accept && (srp_pkg::cmd_t'(cmd) == srp_pkg::CMD_LOAD);

    always_comb
    begin
        state_next        = state_reg;
        rnd_next          = rnd_reg;
        dec_next          = dec_reg;
        dp_cmd            = '0;
        dp_cmd.decrypt    = dec_reg;
        dp_cmd.rnd        = rnd_reg;
        dp_cmd.last       = dec_reg ? (rnd_reg == 5'd31) : (rnd_reg == 5'd31);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (srp_pkg::cmd_t'(cmd) == srp_pkg::CMD_ENCRYPT ||
                               srp_pkg::cmd_t'(cmd) == srp_pkg::CMD_DECRYPT))
                begin
                    dp_cmd.start = 1'b1;
                    dec_next     = (srp_pkg::cmd_t'(cmd) == srp_pkg::CMD_DECRYPT);
                    rnd_next     = dec_next ? 5'd31 : 5'd0;
                    state_next   = ST_RUN;
                end
            end
            ST_RUN:
            begin
                dp_cmd.round = 1'b1;
                if ((dec_reg && rnd_reg == 5'd0) || (!dec_reg && rnd_reg == 5'd31))
                begin
                    dp_cmd.final_perm = 1'b1;
                    state_next        = ST_OUT;
                end
                else
                begin
                    rnd_next = dec_reg ? rnd_reg - 5'd1 : rnd_reg + 5'd1;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Fetch the subkey of the round that runs in the next cycle.
        dp_cmd.key_rnd = rnd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            dec_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            dec_reg   <= dec_next;
        end
    end

endmodule

// ----- design/srp_datapath.sv -----
// Subkey memory and round datapath for the Serpent-128 core.
`timescale 1ns / 1ps
module srp_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  srp_pkg::dp_cmd_t dp_cmd,
    input  logic             key_we,
    input  logic [5:0]       subkey_index,
    input  logic [1:0]       subkey_lane,
    input  logic [31:0]      subkey_word,
    input  logic [63:0]      block_low,
    input  logic [63:0]      block_high,
    output logic [127:0]     data,
    output logic             was_decrypt
);

    logic [127:0] key_mem [srp_pkg::NumSubkeys];
    logic [127:0] blk_reg, blk_next;
    logic         dec_reg;
    logic [127:0] k_rnd_reg, k_last_reg;
    logic [127:0] r_fwd, r_inv, r_out;

    // Write one lane per load; fetch the next round's subkey and subkey 32 each cycle.
    always_ff @(posedge clk)
    begin
        if (key_we && subkey_index < 6'(srp_pkg::NumSubkeys))
        begin
            key_mem[subkey_index][{subkey_lane, 5'd0} +: 32] <= subkey_word;
        end
        k_rnd_reg  <= key_mem[{1'b0, dp_cmd.key_rnd}];
        k_last_reg <= key_mem[6'(srp_pkg::NumSubkeys - 1)];
    end

    always_comb
    begin
        r_fwd = srp_pkg::subst(blk_reg ^ k_rnd_reg, {dp_cmd.rnd[2:0]}, 1'b0);
        r_fwd = dp_cmd.last ? (r_fwd ^ k_last_reg) : srp_pkg::lin_fwd(r_fwd);
        r_inv = dp_cmd.last ? (blk_reg ^ k_last_reg) : srp_pkg::lin_inv(blk_reg);
        r_inv = srp_pkg::subst(r_inv, dp_cmd.rnd[2:0], 1'b1) ^ k_rnd_reg;
        r_out = dp_cmd.decrypt ? r_inv : r_fwd;
        blk_next = blk_reg;
        if (dp_cmd.start)
        begin
            blk_next = srp_pkg::permute({block_high, block_low}, 32);
        end
        else if (dp_cmd.round)
        begin
            blk_next = dp_cmd.final_perm ? srp_pkg::permute(r_out, 4) : r_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_reg <= '0;
            dec_reg <= 1'b0;
        end
        else
        begin
            blk_reg <= blk_next;
            if (dp_cmd.start)
            begin
                dec_reg <= dp_cmd.decrypt;
            end
            else if (dp_cmd.round)
            begin
                dec_reg <= dp_cmd.decrypt;
            end
        end
    end

    assign data        = blk_reg;
    assign was_decrypt = dec_reg;

endmodule

// ----- design/serpent_block_cipher_core.sv -----
// Serpent-128 block cipher core top level: sequencer plus round datapath.
// A block request is accepted, the rounds follow (one per cycle through a
// single shared round unit), then the result is offered until it is taken.
// A new block request is accepted only once the previous result has been taken.
// A subkey load request is written when it is accepted and gives no result.
// Reset (rst_n, async, active low) clears the sequencer and working block; the subkey
// table is not cleared and must be loaded before use.
`timescale 1ns / 1ps
module serpent_block_cipher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [5:0]  subkey_index,
    input  logic [1:0]  subkey_lane,
    input  logic [31:0] subkey_word,
    input  logic [63:0] block_low,
    input  logic [63:0] block_high,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] data_low,
    output logic [63:0] data_high,
    output logic        was_decrypt
);

    srp_pkg::dp_cmd_t dp_cmd;
    logic             key_we;
    logic [127:0]     data;

    // Sequencer: accept requests, step the round counter, hold the result.
    srp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .dp_cmd    (dp_cmd),
        .key_we    (key_we)
    );

    // Datapath: subkey table with a registered read in the cycle before each round,
    // and one full round per cycle.
    srp_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .key_we       (key_we),
        .subkey_index (subkey_index),
        .subkey_lane  (subkey_lane),
        .subkey_word  (subkey_word),
        .block_low    (block_low),
        .block_high   (block_high),
        .data         (data),
        .was_decrypt  (was_decrypt)
    );

    assign data_low  = data[63:0];
    assign data_high = data[127:64];

`ifndef SYNTHESIS
    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(data_low) && $stable(data_high)))
        else $error("result changed while stalled");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.start |-> (in_ready && !dp_cmd.round))
        else $error("start outside idle");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the Serpent-128 block cipher core.
`timescale 1ns / 1ps
module tb;

    // Pending request as the driver sees it.
    typedef struct packed {
        srp_pkg::cmd_t op;
        logic [5:0]    kidx;
        logic [1:0]    lane;
        logic [31:0]   kword;
        logic [63:0]   blo;
        logic [63:0]   bhi;
    } req_t;

    // Expected cipher result.
    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        dec;
    } blk_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = srp_pkg::CMD_NONE;
    logic [5:0]  subkey_index = '0;
    logic [1:0]  subkey_lane = '0;
    logic [31:0] subkey_word = '0;
    logic [63:0] block_low = '0;
    logic [63:0] block_high = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic        was_decrypt;

    req_t     pending_reqs[$];
    blk_res_t expected_blocks[$];
    int       error_count = 0;

    // Predictor copy of the subkey table.
    logic [31:0] key_copy[33][4];

    // Published S-box rows, entry 0 first.
    localparam int SB[8][16] = '{
        '{3, 8, 15, 1, 10, 6, 5, 11, 14, 13, 4, 2, 7, 0, 9, 12},
        '{15, 12, 2, 7, 9, 0, 5, 10, 1, 11, 14, 8, 6, 13, 3, 4},
        '{8, 6, 7, 9, 3, 12, 10, 15, 13, 1, 14, 4, 0, 11, 5, 2},
        '{0, 15, 11, 8, 12, 9, 6, 3, 13, 1, 2, 4, 10, 7, 5, 14},
        '{1, 15, 8, 3, 12, 0, 11, 6, 2, 5, 4, 10, 9, 14, 7, 13},
        '{15, 5, 2, 11, 4, 10, 9, 12, 0, 3, 14, 8, 13, 6, 7, 1},
        '{7, 2, 12, 5, 8, 4, 6, 11, 14, 9, 1, 15, 13, 3, 10, 0},
        '{1, 13, 15, 0, 14, 8, 2, 11, 7, 4, 12, 10, 9, 3, 5, 6}
    };

    always #2 clk = ~clk;

    function automatic logic [127:0] bit_shuffle(input logic [127:0] x, input int m);
        logic [127:0] t;
        for (int i = 0; i < 127; i++) t[i] = x[(m * i) % 127];
        t[127] = x[127];
        return t;
    endfunction

    function automatic logic [31:0] rol(input logic [31:0] v, input int n);
        return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
    endfunction

    function automatic logic [127:0] mix_layer(input logic [127:0] w, input bit inv);
        logic [127:0] p;
        logic [31:0]  x0, x1, x2, x3;
        p = bit_shuffle(w, 4);
        {x3, x2, x1, x0} = p;
        if (!inv) begin
            x0 = rol(x0, 13); x2 = rol(x2, 3);
            x1 ^= x0 ^ x2; x3 ^= x2 ^ (x0 << 3);
            x1 = rol(x1, 1); x3 = rol(x3, 7);
            x0 ^= x1 ^ x3; x2 ^= x3 ^ (x1 << 7);
            x0 = rol(x0, 5); x2 = rol(x2, 22);
        end else begin
            x2 = rol(x2, 10); x0 = rol(x0, 27);
            x2 ^= x3 ^ (x1 << 7); x0 ^= x1 ^ x3;
            x3 = rol(x3, 25); x1 = rol(x1, 31);
            x3 ^= x2 ^ (x0 << 3); x1 ^= x0 ^ x2;
            x2 = rol(x2, 29); x0 = rol(x0, 19);
        end
        return bit_shuffle({x3, x2, x1, x0}, 32);
    endfunction

    function automatic logic [127:0] nibble_sub(input logic [127:0] w, input int box,
                                                input bit inv);
        logic [127:0] r;
        for (int n = 0; n < 32; n++) begin
            if (!inv) r[n*4 +: 4] = 4'(SB[box][w[n*4 +: 4]]);
            else begin
                for (int v = 0; v < 16; v++)
                    if (SB[box][v] == int'(w[n*4 +: 4])) r[n*4 +: 4] = 4'(v);
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] round_key(input int k);
        return {key_copy[k][3], key_copy[k][2], key_copy[k][1], key_copy[k][0]};
    endfunction

    function automatic blk_res_t cipher_block(input req_t rq);
        logic [127:0] w;
        blk_res_t     res;
        w = bit_shuffle({rq.bhi, rq.blo}, 32);
        if (rq.op == srp_pkg::CMD_ENCRYPT) begin
            for (int r = 0; r < 32; r++) begin
                w = nibble_sub(w ^ round_key(r), r % 8, 1'b0);
                w = (r < 31) ? mix_layer(w, 1'b0) : (w ^ round_key(32));
            end
        end else begin
            for (int r = 31; r >= 0; r--) begin
                w = (r < 31) ? mix_layer(w, 1'b1) : (w ^ round_key(32));
                w = nibble_sub(w, r % 8, 1'b1) ^ round_key(r);
            end
        end
        w = bit_shuffle(w, 4);
        res.lo = w[63:0];
        res.hi = w[127:64];
        res.dec = (rq.op == srp_pkg::CMD_DECRYPT);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR %0t: %s got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic req_t key_req(input int idx, input int ln, input logic [31:0] v);
        req_t rq;
        rq = '{op: srp_pkg::CMD_LOAD, kidx: idx[5:0], lane: ln[1:0], kword: v,
               blo: {$urandom, $urandom}, bhi: {$urandom, $urandom}};
        return rq;
    endfunction

    function automatic req_t block_req(input srp_pkg::cmd_t op, input logic [63:0] lo,
                                       input logic [63:0] hi);
        req_t rq;
        rq = '{op: op, kidx: 6'($urandom), lane: 2'($urandom), kword: $urandom,
               blo: lo, bhi: hi};
        return rq;
    endfunction

    // Driver: present one queued request at a time after a random gap.
    int drv_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                // Predict on acceptance: key writes update the copy, blocks queue a result.
                if (cmd == srp_pkg::CMD_LOAD) begin
                    if (subkey_index < 33) key_copy[subkey_index][subkey_lane] = subkey_word;
                end else if (cmd != srp_pkg::CMD_NONE) begin
                    expected_blocks.push_back(cipher_block('{op: srp_pkg::cmd_t'(cmd),
                        kidx: subkey_index, lane: subkey_lane, kword: subkey_word,
                        blo: block_low, bhi: block_high}));
                end
                drv_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) drv_gap = 0;
            end
            if (!in_valid || in_ready) begin
                // Lower valid or hand over the next request.
                if (drv_gap == 0 && pending_reqs.size() > 0) begin
                    req_t rq;
                    rq = pending_reqs.pop_front();
                    in_valid     <= 1'b1;
                    cmd          <= rq.op;
                    subkey_index <= rq.kidx;
                    subkey_lane  <= rq.lane;
                    subkey_word  <= rq.kword;
                    block_low    <= rq.blo;
                    block_high   <= rq.bhi;
                end else begin
                    in_valid <= 1'b0;
                    if (drv_gap > 0) drv_gap--;
                end
            end
        end
    end

    // Monitor: stall the result side at random and check each accepted result.
    int mon_gap = 0;
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_blocks.size() == 0) begin
                    report_mismatch("unexpected result", data_low, 64'd0);
                end else begin
                    blk_res_t want;
                    want = expected_blocks.pop_front();
                    if (data_low !== want.lo) report_mismatch("data_low", data_low, want.lo);
                    if (data_high !== want.hi) report_mismatch("data_high", data_high, want.hi);
                    if (was_decrypt !== want.dec)
                        report_mismatch("was_decrypt", 64'(was_decrypt), 64'(want.dec));
                end
                mon_gap = $urandom_range(0, 9);
                if ($urandom_range(0, 3) == 0) mon_gap = 0;
            end
            if (mon_gap > 0) begin
                mon_gap--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    serpent_block_cipher_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .subkey_index (subkey_index),
        .subkey_lane  (subkey_lane),
        .subkey_word  (subkey_word),
        .block_low    (block_low),
        .block_high   (block_high),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_low     (data_low),
        .data_high    (data_high),
        .was_decrypt  (was_decrypt)
    );

    // Fill the request queue, then wait for every result to drain.
    initial begin
        logic [31:0]   kval;
        int            sel;
        srp_pkg::cmd_t op;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Full key set first so no block ever reads an unwritten subkey.
        for (int k = 0; k < 33; k++)
            for (int l = 0; l < 4; l++) begin
                kval = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;
                pending_reqs.push_back(key_req(k, l, kval));
            end
        // Directed: field extremes, both directions, ignored index and command.
        pending_reqs.push_back(block_req(srp_pkg::CMD_ENCRYPT, 64'd0, 64'd0));
        pending_reqs.push_back(block_req(srp_pkg::CMD_DECRYPT, 64'd0, 64'd0));
        pending_reqs.push_back(block_req(srp_pkg::CMD_ENCRYPT, '1, '1));
        pending_reqs.push_back(block_req(srp_pkg::CMD_DECRYPT, '1, '1));
        pending_reqs.push_back(block_req(srp_pkg::CMD_ENCRYPT, 64'h1,
                                         64'h8000_0000_0000_0000));
        pending_reqs.push_back(key_req(33, 0, '1));
        pending_reqs.push_back(key_req(63, 3, '1));
        pending_reqs.push_back(block_req(srp_pkg::CMD_NONE, '1, '1));
        pending_reqs.push_back(block_req(srp_pkg::CMD_DECRYPT, 64'h1,
                                         64'h8000_0000_0000_0000));
        pending_reqs.push_back(key_req(32, 3, 32'h8000_0001));
        pending_reqs.push_back(block_req(srp_pkg::CMD_ENCRYPT, {$urandom, $urandom}, 64'd0));

        // Random mix: mostly blocks, some key rewrites (including bad indexes) and no-ops.
        for (int n = 0; n < 420; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                pending_reqs.push_back(key_req($urandom_range(0, 63), $urandom_range(0, 3),
                                               $urandom));
            end else if (sel < 25) begin
                pending_reqs.push_back(block_req(srp_pkg::CMD_NONE, {$urandom, $urandom},
                                                 {$urandom, $urandom}));
            end else begin
                op = (sel < 62) ? srp_pkg::CMD_ENCRYPT : srp_pkg::CMD_DECRYPT;
                pending_reqs.push_back(block_req(op, {$urandom, $urandom},
                                                 {$urandom, $urandom}));
            end
        end

        while (pending_reqs.size() > 0 || in_valid || expected_blocks.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
